// ----- rtl/indexed_min_heap_unique_unit_macros.svh -----
// Assertion macros used by the checker file of this block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef INDEXED_MIN_HEAP_UNIQUE_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_UNIQUE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMHU_ASSERT_IMP(name, a, c) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("heap unit assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define IMHU_ASSERT_NXT(name, a, c) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("heap unit assertion failed");

`endif

// ----- rtl/imhu_pkg.sv -----
`timescale 1ns / 1ps

package imhu_pkg;

    localparam int unsigned CAPACITY  = 1024;
    localparam int unsigned KEY_WIDTH = 32;

    typedef enum logic [1:0] {
        FN_PUSH,
        FN_POP,
        FN_ERASE,
        FN_FIND
    } t_func;

    typedef enum logic [2:0] {
        ST_OK,
        ST_DUP,
        ST_ABSENT,
        ST_EMPTY,
        ST_FULL
    } t_status;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_NOP,
        OP_SCAN_RD,
        OP_SCAN_CMP,
        OP_SET_DUP,
        OP_SET_ABSENT,
        OP_SET_EMPTY,
        OP_SET_FULL,
        OP_SET_FOUND,
        OP_PUSH_START,
        OP_RM_START,
        OP_RM_LOAD,
        OP_UP_RD,
        OP_UP_CMP,
        OP_DN_RDL,
        OP_DN_L,
        OP_DN_R,
        OP_DN_CMP,
        OP_PLACE,
        OP_FIN_RD,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        t_func func;
        logic  empty;
        logic  full;
        logic  match;
        logic  scan_end;
        logic  at_root;
        logic  is_last;
        logic  up_less;
        logic  moved;
        logic  has_left;
        logic  has_right;
        logic  dn_less;
        logic  out_free;
    } t_sts;

endpackage

// ----- rtl/imhu_datapath.sv -----
`timescale 1ns / 1ps

module imhu_datapath #(
    parameter int unsigned CAPACITY  = imhu_pkg::CAPACITY,
    parameter int unsigned KEY_WIDTH = imhu_pkg::KEY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  imhu_pkg::t_cmd     i_cmd,
    output imhu_pkg::t_sts     o_sts,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_key_value,
    input  logic               i_stall,
    output logic               o_valid,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_min_key,
    output logic [10:0]        o_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    logic [KEY_WIDTH-1:0] r_heap [CAPACITY];
    logic [KEY_WIDTH-1:0] r_rdata;

    imhu_pkg::t_func      r_func;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] r_cur;
    logic [KEY_WIDTH-1:0] r_bval;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_i;
    logic [CW-1:0]        r_bidx;
    logic                 r_moved;
    imhu_pkg::t_status    r_status;
    logic                 r_found;

    logic                 r_ovalid;
    imhu_pkg::t_status    r_ostatus;
    logic                 r_ofound;
    logic [KEY_WIDTH-1:0] r_omin;
    logic [CW-1:0]        r_ocnt;

    logic [CW-1:0]        w_parent;
    logic [CW-1:0]        w_last;
    logic [CW:0]          w_left;
    logic [CW:0]          w_right;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_we;
    logic [KEY_WIDTH-1:0] w_wdata;
    logic                 w_up_less;
    logic                 w_dn_less;
    logic                 w_right_less;
    logic                 w_match;
    logic                 w_out_free;

    assign w_parent     = (r_i - CW'(1)) >> 1;
    assign w_last       = r_cnt - CW'(1);
    assign w_left       = {r_i, 1'b1};
    assign w_right      = w_left + (CW + 1)'(1);
    assign w_up_less    = $signed(r_cur) < $signed(r_rdata);
    assign w_dn_less    = $signed(r_bval) < $signed(r_cur);
    assign w_right_less = $signed(r_rdata) < $signed(r_bval);
    assign w_match      = r_rdata == r_key;
    assign w_out_free   = !r_ovalid || !i_stall;

    always_comb begin
        case (i_cmd.op)
            imhu_pkg::OP_SCAN_RD:  w_rd_addr = r_i[AW-1:0];
            imhu_pkg::OP_RM_START: w_rd_addr = w_last[AW-1:0];
            imhu_pkg::OP_UP_RD:    w_rd_addr = w_parent[AW-1:0];
            imhu_pkg::OP_DN_RDL:   w_rd_addr = w_left[AW-1:0];
            imhu_pkg::OP_DN_L:     w_rd_addr = w_right[AW-1:0];
            default:               w_rd_addr = '0;
        endcase
    end

    // The moving key rides in r_cur while the hole walks; it is written once at the end.
    always_comb begin
        case (i_cmd.op)
            imhu_pkg::OP_UP_CMP: begin
                w_we    = w_up_less;
                w_wdata = r_rdata;
            end
            imhu_pkg::OP_DN_CMP: begin
                w_we    = w_dn_less;
                w_wdata = r_bval;
            end
            imhu_pkg::OP_PLACE: begin
                w_we    = 1'b1;
                w_wdata = r_cur;
            end
            default: begin
                w_we    = 1'b0;
                w_wdata = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_heap[r_i[AW-1:0]] <= w_wdata;
        end
        r_rdata <= r_heap[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.op == imhu_pkg::OP_FIN && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (i_cmd.op)
                imhu_pkg::OP_LOAD: begin
                    r_func   <= imhu_pkg::t_func'(i_func);
                    r_key    <= KEY_WIDTH'($signed(i_key_value));
                    r_i      <= '0;
                    r_moved  <= 1'b0;
                    r_status <= imhu_pkg::ST_OK;
                    r_found  <= 1'b0;
                end
                imhu_pkg::OP_SCAN_CMP: begin
                    if (!w_match) begin
                        r_i <= r_i + CW'(1);
                    end
                end
                imhu_pkg::OP_SET_DUP:    r_status <= imhu_pkg::ST_DUP;
                imhu_pkg::OP_SET_ABSENT: r_status <= imhu_pkg::ST_ABSENT;
                imhu_pkg::OP_SET_EMPTY:  r_status <= imhu_pkg::ST_EMPTY;
                imhu_pkg::OP_SET_FULL:   r_status <= imhu_pkg::ST_FULL;
                imhu_pkg::OP_SET_FOUND:  r_found  <= 1'b1;
                imhu_pkg::OP_PUSH_START: begin
                    r_cur <= r_key;
                    r_i   <= r_cnt;
                    r_cnt <= r_cnt + CW'(1);
                end
                imhu_pkg::OP_RM_START: r_cnt <= w_last;
                imhu_pkg::OP_RM_LOAD:  r_cur <= r_rdata;
                imhu_pkg::OP_UP_CMP: begin
                    if (w_up_less) begin
                        r_i     <= w_parent;
                        r_moved <= 1'b1;
                    end
                end
                imhu_pkg::OP_DN_L: begin
                    r_bval <= r_rdata;
                    r_bidx <= w_left[CW-1:0];
                end
                imhu_pkg::OP_DN_R: begin
                    if (w_right_less) begin
                        r_bval <= r_rdata;
                        r_bidx <= w_right[CW-1:0];
                    end
                end
                imhu_pkg::OP_DN_CMP: begin
                    if (w_dn_less) begin
                        r_i <= r_bidx;
                    end
                end
                imhu_pkg::OP_FIN: begin
                    if (w_out_free) begin
                        r_ostatus <= r_status;
                        r_ofound  <= r_found;
                        r_omin    <= (r_cnt == '0) ? '0 : r_rdata;
                        r_ocnt    <= r_cnt;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_sts.func      = r_func;
    assign o_sts.empty     = r_cnt == '0;
    assign o_sts.full      = r_cnt == CW'(CAPACITY);
    assign o_sts.match     = w_match;
    assign o_sts.scan_end  = (r_i + CW'(1)) == r_cnt;
    assign o_sts.at_root   = r_i == '0;
    assign o_sts.is_last   = r_i == w_last;
    assign o_sts.up_less   = w_up_less;
    assign o_sts.moved     = r_moved;
    assign o_sts.has_left  = w_left < {1'b0, r_cnt};
    assign o_sts.has_right = w_right < {1'b0, r_cnt};
    assign o_sts.dn_less   = w_dn_less;
    assign o_sts.out_free  = w_out_free;

    assign o_valid   = r_ovalid;
    assign o_status  = r_ostatus;
    assign o_found   = r_ofound;
    assign o_min_key = 32'($signed(r_omin));
    assign o_count   = 11'(r_ocnt);

endmodule

// ----- rtl/imhu_ctrl.sv -----
`timescale 1ns / 1ps

module imhu_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  imhu_pkg::t_sts i_sts,
    output imhu_pkg::t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_DUP,
        S_ABSENT,
        S_EMPTY,
        S_FULL,
        S_FOUND,
        S_PUSH,
        S_RM,
        S_RM_LOAD,
        S_UP,
        S_UP_CMP,
        S_DN,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_PLACE,
        S_FIN_RD,
        S_FIN
    } t_state;

    t_state          r_state;
    t_state          n_state;
    t_state          w_up_done;
    imhu_pkg::t_cmd  r_cmd;

    function automatic imhu_pkg::t_op op_for(input t_state s);
        case (s)
            S_IDLE:     return imhu_pkg::OP_LOAD;
            S_SCAN_RD:  return imhu_pkg::OP_SCAN_RD;
            S_SCAN_CMP: return imhu_pkg::OP_SCAN_CMP;
            S_DUP:      return imhu_pkg::OP_SET_DUP;
            S_ABSENT:   return imhu_pkg::OP_SET_ABSENT;
            S_EMPTY:    return imhu_pkg::OP_SET_EMPTY;
            S_FULL:     return imhu_pkg::OP_SET_FULL;
            S_FOUND:    return imhu_pkg::OP_SET_FOUND;
            S_PUSH:     return imhu_pkg::OP_PUSH_START;
            S_RM:       return imhu_pkg::OP_RM_START;
            S_RM_LOAD:  return imhu_pkg::OP_RM_LOAD;
            S_UP:       return imhu_pkg::OP_UP_RD;
            S_UP_CMP:   return imhu_pkg::OP_UP_CMP;
            S_DN:       return imhu_pkg::OP_DN_RDL;
            S_DN_L:     return imhu_pkg::OP_DN_L;
            S_DN_R:     return imhu_pkg::OP_DN_R;
            S_DN_CMP:   return imhu_pkg::OP_DN_CMP;
            S_PLACE:    return imhu_pkg::OP_PLACE;
            S_FIN_RD:   return imhu_pkg::OP_FIN_RD;
            S_FIN:      return imhu_pkg::OP_FIN;
            default:    return imhu_pkg::OP_NOP;
        endcase
    endfunction

    // A removal whose replacement key did not rise must still sink.
    assign w_up_done = (i_sts.func == imhu_pkg::FN_PUSH || i_sts.moved) ? S_PLACE : S_DN;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.func)
                    imhu_pkg::FN_PUSH:  n_state = i_sts.empty ? S_PUSH : S_SCAN_RD;
                    imhu_pkg::FN_POP:   n_state = i_sts.empty ? S_EMPTY : S_RM;
                    imhu_pkg::FN_ERASE: n_state = i_sts.empty ? S_EMPTY : S_SCAN_RD;
                    default:            n_state = i_sts.empty ? S_ABSENT : S_SCAN_RD;
                endcase
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    case (i_sts.func)
                        imhu_pkg::FN_PUSH:  n_state = S_DUP;
                        imhu_pkg::FN_ERASE: n_state = S_RM;
                        default:            n_state = S_FOUND;
                    endcase
                end else if (i_sts.scan_end) begin
                    if (i_sts.func == imhu_pkg::FN_PUSH) begin
                        n_state = i_sts.full ? S_FULL : S_PUSH;
                    end else begin
                        n_state = S_ABSENT;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_DUP, S_ABSENT, S_EMPTY, S_FULL, S_FOUND: n_state = S_FIN_RD;
            S_PUSH: n_state = S_UP;
            S_RM: n_state = i_sts.is_last ? S_FIN_RD : S_RM_LOAD;
            S_RM_LOAD: n_state = S_UP;
            S_UP: n_state = i_sts.at_root ? w_up_done : S_UP_CMP;
            S_UP_CMP: n_state = i_sts.up_less ? S_UP : w_up_done;
            S_DN: n_state = i_sts.has_left ? S_DN_L : S_PLACE;
            S_DN_L: n_state = i_sts.has_right ? S_DN_R : S_DN_CMP;
            S_DN_R: n_state = S_DN_CMP;
            S_DN_CMP: n_state = i_sts.dn_less ? S_DN : S_PLACE;
            S_PLACE: n_state = S_FIN_RD;
            S_FIN_RD: n_state = S_FIN;
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cmd.op <= imhu_pkg::OP_LOAD;
        end else begin
            r_state  <= n_state;
            r_cmd.op <= op_for(n_state);
        end
    end

    assign o_cmd = r_cmd;

endmodule

// ----- rtl/indexed_min_heap_unique_unit.sv -----
`timescale 1ns / 1ps
// Binary min-heap of distinct signed keys with push, pop, erase and find.
// Request channel: i_valid, o_stall, i_func, i_key_value. A request is taken
// on a clock edge with i_valid high and o_stall low; o_stall is high while a
// request is being worked on, so one request is handled at a time.
// Result channel: o_valid, i_stall, o_status, o_found, o_min_key, o_count.
// Every request yields exactly one result, held in an output register.
// Pop moves the last key to the root and sinks it, reading the left and
// right child and comparing at each level. Push, erase and find first search
// the heap memory linearly for the key, one held key per read, then push
// sifts up, reading and comparing a parent at each level, and erase sifts
// up or down like pop. Each request ends by reading the root for the minimum
// and registering the result; the unit then returns to idle, where it takes
// the next request, so a new request waits until the last one is through.
// When the receiver stalls, the finished result waits in the output register
// and the next request still runs; it holds in its last step only if the
// previous result has not been taken. Synchronous reset empties the heap
// at once and drops any pending result.
module indexed_min_heap_unique_unit #(
    parameter int unsigned CAPACITY  = imhu_pkg::CAPACITY,
    parameter int unsigned KEY_WIDTH = imhu_pkg::KEY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [31:0] i_key_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_status,
    output logic               o_found,
    output logic signed [31:0] o_min_key,
    output logic [10:0]        o_count
);

    imhu_pkg::t_cmd w_cmd;
    imhu_pkg::t_sts w_sts;

    imhu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    imhu_datapath #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_func      (i_func),
        .i_key_value (i_key_value),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_found     (o_found),
        .o_min_key   (o_min_key),
        .o_count     (o_count)
    );

    assign o_stall = w_cmd.op != imhu_pkg::OP_LOAD;

endmodule

// ----- rtl/imhu_checker.sv -----
`timescale 1ns / 1ps
`include "indexed_min_heap_unique_unit_macros.svh"

module imhu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic [2:0]         o_status,
    input logic               o_found,
    input logic signed [31:0] o_min_key,
    input logic [10:0]        o_count
);

    logic [46:0] w_result;

    assign w_result = {o_status, o_found, o_min_key, o_count};

    // A stalled result keeps its contents.
    `IMHU_ASSERT_NXT(a_out_hold, o_valid && i_stall, o_valid && $stable(w_result))

    // A taken request always occupies the unit for at least the next cycle.
    `IMHU_ASSERT_NXT(a_busy_after_req, i_valid && !o_stall, o_stall)

    `IMHU_ASSERT_IMP(a_found_ok, o_valid && o_found, o_status == imhu_pkg::ST_OK)

    `IMHU_ASSERT_IMP(a_empty_min, o_valid && o_count == 11'd0, o_min_key == 32'sd0)

endmodule

bind indexed_min_heap_unique_unit imhu_checker u_imhu_checker (.*);

// ----- dv/indexed_min_heap_unique_unit_tb.sv -----
`timescale 1ns / 1ps

module indexed_min_heap_unique_unit_tb;

    localparam int unsigned HEAP_CAP = imhu_pkg::CAPACITY;
    localparam int unsigned WATCHDOG_LIMIT = 200000;
    localparam int HOLD_OFF_LEN = 300;

    typedef struct packed {
        imhu_pkg::t_func func;
        logic [31:0]     key;
    } t_request;

    typedef struct packed {
        imhu_pkg::t_status status;
        logic              found;
        logic [31:0]       min_key;
        logic [10:0]       count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = '0;
    logic signed [31:0] i_key_value = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic        o_found;
    logic signed [31:0] o_min_key;
    logic [10:0] o_count;

    indexed_min_heap_unique_unit dut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow heap: a plain array kept in heap order, plus a membership map.
    logic signed [31:0] shadow_heap [HEAP_CAP];
    int unsigned        shadow_count;
    bit                 shadow_held [int];

    t_request pending_requests [$];
    t_outcome expected_outcomes [$];
    int       error_count = 0;
    int       send_idle_pct = 0;
    int       recv_stall_pct = 0;
    bit       hold_off_armed = 1'b0;
    bit       hold_off_used = 1'b0;
    int       hold_off_cycles = 0;
    int       quiet_cycles = 0;

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic int unsigned sift_toward_root(int unsigned i);
        int unsigned p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!(shadow_heap[i] < shadow_heap[p])) break;
            swap_entries(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic void sift_toward_leaves(int unsigned i);
        int unsigned l;
        int unsigned best;
        while (2 * i + 1 < shadow_count) begin
            l = 2 * i + 1;
            best = i;
            if (shadow_heap[l] < shadow_heap[best]) best = l;
            if (l + 1 < shadow_count && shadow_heap[l + 1] < shadow_heap[best]) best = l + 1;
            if (best == i) break;
            swap_entries(i, best);
            i = best;
        end
    endfunction

    function automatic void take_slot(int unsigned slot);
        int unsigned last;
        last = shadow_count - 1;
        shadow_held.delete(shadow_heap[slot]);
        shadow_count = last;
        if (slot != last) begin
            shadow_heap[slot] = shadow_heap[last];
            slot = sift_toward_root(slot);
            sift_toward_leaves(slot);
        end
    endfunction

    function automatic t_outcome apply_request(t_request rq);
        t_outcome oc;
        logic signed [31:0] k;
        bit held;
        int unsigned slot;
        k = rq.key;
        held = shadow_held.exists(k);
        oc.status = imhu_pkg::ST_OK;
        oc.found = 1'b0;
        case (rq.func)
            imhu_pkg::FN_PUSH: begin
                if (held) oc.status = imhu_pkg::ST_DUP;
                else if (shadow_count >= HEAP_CAP) oc.status = imhu_pkg::ST_FULL;
                else begin
                    shadow_heap[shadow_count] = k;
                    shadow_held[k] = 1'b1;
                    shadow_count++;
                    void'(sift_toward_root(shadow_count - 1));
                end
            end
            imhu_pkg::FN_POP: begin
                if (shadow_count == 0) oc.status = imhu_pkg::ST_EMPTY;
                else take_slot(0);
            end
            imhu_pkg::FN_ERASE: begin
                if (shadow_count == 0) oc.status = imhu_pkg::ST_EMPTY;
                else if (!held) oc.status = imhu_pkg::ST_ABSENT;
                else begin
                    slot = 0;
                    while (shadow_heap[slot] != k) slot++;
                    take_slot(slot);
                end
            end
            default: begin
                if (held) oc.found = 1'b1;
                else oc.status = imhu_pkg::ST_ABSENT;
            end
        endcase
        oc.min_key = (shadow_count != 0) ? shadow_heap[0] : '0;
        oc.count = shadow_count[10:0];
        return oc;
    endfunction

    // Driver: a valid request stays put until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_func <= pending_requests[0].func;
                i_key_value <= pending_requests[0].key;
                expected_outcomes.push_back(apply_request(pending_requests.pop_front()));
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with one long hold-off counted here once it is armed.
    always @(posedge i_clk) begin
        if (hold_off_armed && !hold_off_used) begin
            hold_off_used <= 1'b1;
            hold_off_cycles <= HOLD_OFF_LEN;
            i_stall <= 1'b1;
        end else if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (o_valid && !i_stall) begin
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result status=%0d count=%0d", $time,
                             o_status, o_count);
                    error_count++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, o_status);
                        error_count++;
                    end
                    if (o_found !== want.found) begin
                        $display("%0t: found expected %0d actual %0d", $time,
                                 want.found, o_found);
                        error_count++;
                    end
                    if (o_min_key !== want.min_key) begin
                        $display("%0t: min_key expected %0d actual %0d", $time,
                                 $signed(want.min_key), o_min_key);
                        error_count++;
                    end
                    if (o_count !== want.count) begin
                        $display("%0t: count expected %0d actual %0d", $time,
                                 want.count, o_count);
                        error_count++;
                    end
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("indexed_min_heap_unique_unit_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic queue_request(imhu_pkg::t_func f, logic [31:0] k);
        t_request rq;
        rq.func = f;
        rq.key = k;
        pending_requests.push_back(rq);
    endtask

    function automatic logic [31:0] pick_key();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return $urandom;
            default: return $urandom_range(63) - 32;
        endcase
    endfunction

    // Pushes are favored over the other requests so sift paths get deep.
    task automatic queue_random(int n);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 45) queue_request(imhu_pkg::FN_PUSH, pick_key());
            else if (r < 65) queue_request(imhu_pkg::FN_POP, $urandom);
            else if (r < 82) queue_request(imhu_pkg::FN_ERASE, pick_key());
            else queue_request(imhu_pkg::FN_FIND, pick_key());
        end
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-heap cases, extremes, duplicates, absent keys.
        queue_request(imhu_pkg::FN_POP, 32'h0);
        queue_request(imhu_pkg::FN_ERASE, 32'h5);
        queue_request(imhu_pkg::FN_FIND, 32'h5);
        queue_request(imhu_pkg::FN_PUSH, 32'h7fff_ffff);
        queue_request(imhu_pkg::FN_PUSH, 32'h8000_0000);
        queue_request(imhu_pkg::FN_PUSH, 32'h0);
        queue_request(imhu_pkg::FN_PUSH, 32'hffff_ffff);
        queue_request(imhu_pkg::FN_PUSH, 32'h8000_0000);
        queue_request(imhu_pkg::FN_FIND, 32'h7fff_ffff);
        queue_request(imhu_pkg::FN_FIND, 32'h1234_5678);
        queue_request(imhu_pkg::FN_ERASE, 32'h1234_5678);
        queue_request(imhu_pkg::FN_ERASE, 32'h0);
        queue_request(imhu_pkg::FN_ERASE, 32'h8000_0000);
        queue_request(imhu_pkg::FN_POP, 32'hffff_ffff);
        queue_request(imhu_pkg::FN_POP, 32'h0);
        queue_request(imhu_pkg::FN_POP, 32'h0);
        queue_request(imhu_pkg::FN_FIND, 32'h7fff_ffff);
        wait_drained();

        send_idle_pct = 0;  recv_stall_pct = 0;  queue_random(100); wait_drained();
        send_idle_pct = 48; recv_stall_pct = 0;  queue_random(100); wait_drained();
        send_idle_pct = 0;  recv_stall_pct = 48; queue_random(100); wait_drained();
        send_idle_pct = 22; recv_stall_pct = 22; queue_random(100); wait_drained();

        // Long receiver hold-off while requests keep coming.
        send_idle_pct = 0; recv_stall_pct = 0;
        hold_off_armed = 1'b1;
        queue_random(60);
        wait_drained();

        // Fill to capacity, try a few more, then take some back out.
        for (int i = 0; i < HEAP_CAP + 4; i++) queue_request(imhu_pkg::FN_PUSH, $urandom);
        wait_drained();
        for (int i = 0; i < 20; i++) queue_request(imhu_pkg::FN_POP, '0);
        wait_drained();

        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_outcomes.size() == 0)
            $display("indexed_min_heap_unique_unit_tb: done, clean");
        else
            $display("indexed_min_heap_unique_unit_tb: done, errors");
        $finish;
    end
endmodule
